// File: sv/shadow_timestamp_table_assert.svh
// Assertion macros for the shadow timestamp table.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef SHADOW_TIMESTAMP_TABLE_ASSERT_SVH
`define SHADOW_TIMESTAMP_TABLE_ASSERT_SVH

// same-cycle implication
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/stt_pkg.sv
// Shared constants, codes and types of the shadow timestamp table.
// No dependencies.
package stt_pkg;

	localparam int WINDOW_BITS = 16;
	localparam int DEPTH       = 1 << WINDOW_BITS;
	localparam int MAX_THR     = 64;
	localparam int RANK_W      = $clog2(MAX_THR + 1);

	localparam int ADDR_W      = 64;
	localparam int VAL_W       = 32;
	localparam int TIDX_W      = 6;
	localparam int TCNT_W      = 7;
	localparam int SHIFT_W     = 3;
	localparam logic [SHIFT_W-1:0] MAX_SHIFT = 3'd4;

	localparam int IN_W        = 112;
	localparam int OUT_W       = 40;

	typedef enum logic [1:0] {
		FN_LOOKUP   = 2'd0,
		FN_INSERT   = 2'd1,
		FN_LOAD_THR = 2'd2,
		FN_COMPRESS = 2'd3
	} stt_func_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_SWEEP
	} stt_state_t;

	typedef struct packed {
		logic                   we;
		logic [WINDOW_BITS-1:0] waddr;
		logic [VAL_W-1:0]       wdata;
		logic                   re;
		logic [WINDOW_BITS-1:0] raddr;
	} stt_mem_req_t;

	typedef struct packed {
		logic                   valid;
		logic                   zero;
		logic [WINDOW_BITS-1:0] idx;
	} stt_sweep_tag_t;

endpackage

// File: sv/stt_store.sv
// Timestamp store: one write port, one read port, registered read data.
// Depends on stt_pkg.
module stt_store (
	input  logic                       clk,
	input  stt_pkg::stt_mem_req_t      req,
	output logic [stt_pkg::VAL_W-1:0]  rdata
);

	logic [stt_pkg::VAL_W-1:0] mem [stt_pkg::DEPTH];
	logic [stt_pkg::VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/stt_rank.sv
// Threshold lanes and rank encoder used by the compress sweep.
// Depends on stt_pkg.
module stt_rank (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          thr_we,
	input  logic [stt_pkg::TIDX_W-1:0]    thr_idx,
	input  logic [stt_pkg::VAL_W-1:0]     thr_val,
	input  logic                          cnt_we,
	input  logic [stt_pkg::TCNT_W-1:0]    cnt_in,
	input  logic [stt_pkg::VAL_W-1:0]     data,
	input  stt_pkg::stt_sweep_tag_t       tag_in,
	output stt_pkg::stt_sweep_tag_t       tag_out,
	output logic [stt_pkg::RANK_W-1:0]    rank
);

	logic [stt_pkg::VAL_W-1:0]       thr_q [stt_pkg::MAX_THR];
	logic [stt_pkg::TCNT_W-1:0]      cnt_q;
	logic [stt_pkg::MAX_THR-1:0]     mask_s2;
	logic                            vld_s2;
	logic                            zero_s2;
	logic [stt_pkg::WINDOW_BITS-1:0] idx_s2;

	always_ff @(posedge clk) begin
		for (int k = 0; k < stt_pkg::MAX_THR; k++) begin
			if (thr_we && (32'(thr_idx) == 32'(k))) begin
				thr_q[k] <= thr_val;
			end
		end
		if (cnt_we) begin
			cnt_q <= cnt_in;
		end
	end

	// lanes at or above the count drop out, which also saturates the count
	always_ff @(posedge clk) begin
		for (int k = 0; k < stt_pkg::MAX_THR; k++) begin
			mask_s2[k] <= (thr_q[k] <= data) && (32'(k) < 32'(cnt_q));
		end
		zero_s2 <= tag_in.zero;
		idx_s2  <= tag_in.idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= tag_in.valid;
		end
	end

	always_comb begin
		rank = '0;
		for (int k = 0; k < stt_pkg::MAX_THR; k++) begin
			if (mask_s2[k]) begin
				rank = stt_pkg::RANK_W'(k + 1);
			end
		end
	end

	assign tag_out = '{valid: vld_s2, zero: zero_s2, idx: idx_s2};

endmodule

// File: sv/shadow_timestamp_table.sv
// Top level of the shadow timestamp table: request pipeline, sweep control, result register.
// Depends on stt_pkg, stt_store, stt_rank and shadow_timestamp_table_assert.svh.
//
// After reset the store is cleared one entry per cycle with s_tready low (granule_shift
// writes are taken throughout). Lookup, insert and threshold load then run at one
// request per cycle while m_tready lets the result register drain; each result passes
// the request stage and the result register, with same-entry insert-then-read
// forwarded past the store's single read port. A compress request holds the pipeline
// while it walks all 65536 entries through the store's read and write ports, one entry
// a cycle; its result is registered after the sweep drains, then requests resume.
`include "shadow_timestamp_table_assert.svh"

module shadow_timestamp_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [stt_pkg::SHIFT_W-1:0]    cfg_wdata,   // granule_shift
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// func[1:0], address[65:2], value_in[97:66], thr_index[103:98], thr_count[110:104]
	input  logic [stt_pkg::IN_W-1:0]       s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_value[31:0], out_of_window[32], op_done[33]
	output logic [stt_pkg::OUT_W-1:0]      m_tdata
);

	localparam int IW = stt_pkg::WINDOW_BITS;

	stt_pkg::stt_state_t         st_q, st_d;
	logic [IW-1:0]               ptr_q, ptr_d;
	logic                        sw_rd_q, sw_rd_d;
	logic                        sw_v_s1;
	logic [IW-1:0]               sw_idx_s1;
	logic [stt_pkg::SHIFT_W-1:0] shift_q;

	stt_pkg::stt_func_t          in_func;
	logic [stt_pkg::ADDR_W-1:0]  in_addr;
	logic [stt_pkg::VAL_W-1:0]   in_val;
	logic [stt_pkg::TIDX_W-1:0]  in_tidx;
	logic [stt_pkg::TCNT_W-1:0]  in_tcnt;
	logic [stt_pkg::SHIFT_W-1:0] eff_shift;
	logic [IW-1:0]               in_idx;
	logic                        in_oow;
	logic                        s_acc;

	logic                        vld_s1;
	stt_pkg::stt_func_t          func_s1;
	logic [IW-1:0]               idx_s1;
	logic [stt_pkg::VAL_W-1:0]   wval_s1;
	logic                        oow_s1;
	logic                        fwd_s1;
	logic [stt_pkg::VAL_W-1:0]   fwd_val_s1;

	logic                        sweep_fin;
	logic                        s1_done;
	logic                        s1_adv;
	logic                        s1_wr;
	logic [stt_pkg::VAL_W-1:0]   rd_val;
	logic [stt_pkg::VAL_W-1:0]   res_val;

	logic                        m_vld_q;
	logic [stt_pkg::VAL_W-1:0]   m_rv_q;
	logic                        m_oow_q;

	stt_pkg::stt_mem_req_t       mem_req;
	logic [stt_pkg::VAL_W-1:0]   mem_rdata;
	stt_pkg::stt_sweep_tag_t     rk_tag_in;
	stt_pkg::stt_sweep_tag_t     rk_tag;
	logic [stt_pkg::RANK_W-1:0]  rk_rank;

	logic                        clearing;
	logic                        sweeping;
	logic                        cmp_wait;
	logic                        sw_both;

	assign in_func = stt_pkg::stt_func_t'(s_tdata[1:0]);
	assign in_addr = s_tdata[65:2];
	assign in_val  = s_tdata[97:66];
	assign in_tidx = s_tdata[103:98];
	assign in_tcnt = s_tdata[110:104];

	assign eff_shift = (shift_q > stt_pkg::MAX_SHIFT) ? stt_pkg::MAX_SHIFT : shift_q;
	assign in_idx    = in_addr[IW-1:0] >> eff_shift;
	assign in_oow    = |in_addr[stt_pkg::ADDR_W-1:IW];

	assign sweep_fin = !sw_rd_q && !sw_v_s1 && !rk_tag.valid;
	assign s1_done   = vld_s1 && ((func_s1 != stt_pkg::FN_COMPRESS)
		|| ((st_q == stt_pkg::ST_SWEEP) && sweep_fin));
	assign s1_adv    = s1_done && (!m_vld_q || m_tready);
	assign s1_wr     = s1_adv && (func_s1 == stt_pkg::FN_INSERT) && !oow_s1;
	assign s_tready  = (st_q == stt_pkg::ST_RUN) && (!vld_s1 || s1_adv);
	assign s_acc     = s_tvalid && s_tready;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (cfg_we) begin
			shift_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= stt_pkg::ST_CLEAR;
			ptr_q   <= '0;
			sw_rd_q <= 1'b0;
			sw_v_s1 <= 1'b0;
		end else begin
			st_q    <= st_d;
			ptr_q   <= ptr_d;
			sw_rd_q <= sw_rd_d;
			sw_v_s1 <= (st_q == stt_pkg::ST_SWEEP) && sw_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		sw_idx_s1 <= ptr_q;
	end

	always_comb begin
		st_d    = st_q;
		ptr_d   = ptr_q;
		sw_rd_d = sw_rd_q;
		case (st_q)
			stt_pkg::ST_CLEAR: begin
				ptr_d = ptr_q + 1'b1;
				if (&ptr_q) begin
					st_d = stt_pkg::ST_RUN;
				end
			end
			stt_pkg::ST_RUN: begin
				if (vld_s1 && (func_s1 == stt_pkg::FN_COMPRESS)) begin
					st_d    = stt_pkg::ST_SWEEP;
					ptr_d   = '0;
					sw_rd_d = 1'b1;
				end
			end
			stt_pkg::ST_SWEEP: begin
				if (sw_rd_q) begin
					ptr_d = ptr_q + 1'b1;
					if (&ptr_q) begin
						sw_rd_d = 1'b0;
					end
				end
				if (s1_adv) begin
					st_d = stt_pkg::ST_RUN;
				end
			end
			default: begin
				st_d = stt_pkg::ST_CLEAR;
			end
		endcase
	end

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			func_s1    <= in_func;
			idx_s1     <= in_idx;
			wval_s1    <= in_val;
			oow_s1     <= in_oow;
			fwd_s1     <= s1_wr && (idx_s1 == in_idx);
			fwd_val_s1 <= wval_s1;
		end
	end

	assign rd_val  = fwd_s1 ? fwd_val_s1 : mem_rdata;
	assign res_val = (((func_s1 == stt_pkg::FN_LOOKUP) || (func_s1 == stt_pkg::FN_INSERT))
		&& !oow_s1) ? rd_val : '0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (s1_adv) begin
			m_vld_q <= 1'b1;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_rv_q  <= res_val;
			m_oow_q <= oow_s1 && ((func_s1 == stt_pkg::FN_LOOKUP)
				|| (func_s1 == stt_pkg::FN_INSERT));
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {6'b0, 1'b1, m_oow_q, m_rv_q};

	// store port arbitration
	always_comb begin
		mem_req = '0;
		case (st_q)
			stt_pkg::ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ptr_q;
			end
			stt_pkg::ST_RUN: begin
				mem_req.we    = s1_wr;
				mem_req.waddr = idx_s1;
				mem_req.wdata = wval_s1;
				mem_req.re    = s_acc;
				mem_req.raddr = in_idx;
			end
			stt_pkg::ST_SWEEP: begin
				mem_req.we    = rk_tag.valid && !rk_tag.zero;
				mem_req.waddr = rk_tag.idx;
				mem_req.wdata = {{(stt_pkg::VAL_W - stt_pkg::RANK_W){1'b0}}, rk_rank};
				mem_req.re    = sw_rd_q;
				mem_req.raddr = ptr_q;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	stt_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign rk_tag_in.valid = sw_v_s1;
	assign rk_tag_in.zero  = (mem_rdata == '0);
	assign rk_tag_in.idx   = sw_idx_s1;

	stt_rank u_rank (
		.clk     (clk),
		.arst_n  (arst_n),
		.thr_we  (s_acc && (in_func == stt_pkg::FN_LOAD_THR)),
		.thr_idx (in_tidx),
		.thr_val (in_val),
		.cnt_we  (s_acc && (in_func == stt_pkg::FN_COMPRESS)),
		.cnt_in  (in_tcnt),
		.data    (mem_rdata),
		.tag_in  (rk_tag_in),
		.tag_out (rk_tag),
		.rank    (rk_rank)
	);

	assign clearing = (st_q == stt_pkg::ST_CLEAR);
	assign sweeping = (st_q == stt_pkg::ST_SWEEP);
	assign cmp_wait = (st_q == stt_pkg::ST_RUN) && vld_s1 && (func_s1 == stt_pkg::FN_COMPRESS);
	assign sw_both  = sweeping && sw_rd_q && mem_req.we;

	`STT_ASSERT_IMP(a_clear_empty, clearing, !vld_s1 && !m_vld_q, "request during clear")
	`STT_ASSERT_IMP(a_sweep_closed, sweeping, !s_tready, "ready during sweep")
	`STT_ASSERT_NXT(a_sweep_start, cmp_wait, sweeping, "compress did not start sweep")
	`STT_ASSERT_IMP(a_sweep_order, sw_both, mem_req.waddr < ptr_q, "sweep write overtook read")

endmodule
